@@ design/itda_pkg.sv @@
// Shared types and constants for the integer to decimal ASCII converter.
`default_nettype none

package itda_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned DigitCount = 10;
  localparam int unsigned BcdWidth   = 4 * DigitCount;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharMinus = 8'h2D;

  typedef logic [BcdWidth-1:0] bcd_t;

endpackage

`default_nettype wire

@@ design/integer_to_decimal_ascii_core.sv @@
// Top level: 32-bit integer to decimal ASCII text, one character per beat.
//
//   channel | direction | fields              | handshake
//   --------+-----------+---------------------+-----------------------
//   in      | input     | kind_i, value_i     | in_valid_i / in_ready_o
//   out     | output    | character_o,        | out_valid_o / out_ready_i
//           |           | is_last_o           |
//
// A number is accepted, converted by double dabble on one shared
// add-3/shift unit, then leading zero digits are dropped, an optional
// sign character goes out, and the digits follow, one digit per cycle
// while the sink takes each beat at once. in_ready_o is high only
// while idle; the
// output register may still hold the last character of the previous number
// when the next number is accepted. Reset (rst_ni low) clears the sequencer
// and the output valid; a stalled sink holds the current beat and pauses
// the character stepping.
`default_nettype none

module integer_to_decimal_ascii_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  character_o,
  output logic        is_last_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StConv = 3'd1;
  localparam logic [2:0] StSkip = 3'd2;
  localparam logic [2:0] StSign = 3'd3;
  localparam logic [2:0] StEmit = 3'd4;

  localparam int unsigned StepBits = $clog2(itda_pkg::ValueWidth);
  localparam int unsigned DigBits  = $clog2(itda_pkg::DigitCount + 1);

  logic [2:0]                       state_q, state_d;
  logic [itda_pkg::ValueWidth-1:0]  bin_q, bin_d;
  itda_pkg::bcd_t                   bcd_q, bcd_d;
  itda_pkg::bcd_t                   bcd_step;
  logic [StepBits-1:0]              step_q, step_d;
  logic [DigBits-1:0]               ndig_q, ndig_d;
  logic                             neg_q, neg_d;
  logic                             ov_q, ov_d;
  logic [7:0]                       char_q, char_d;
  logic                             last_q, last_d;

  logic                             in_beat;
  logic                             slot_free;
  logic [3:0]                       top_dig;

  assign in_ready_o  = (state_q == StIdle);
  assign in_beat     = in_valid_i && in_ready_o;
  assign slot_free   = !ov_q || out_ready_i;
  assign top_dig     = bcd_q[itda_pkg::BcdWidth-1 -: 4];

  assign out_valid_o = ov_q;
  assign character_o = char_q;
  assign is_last_o   = last_q;

  // Shared arithmetic: add-3 then shift in the next magnitude bit.
  itda_bcd_step u_step (
    .bcd_i (bcd_q),
    .bit_i (bin_q[itda_pkg::ValueWidth-1]),
    .bcd_o (bcd_step)
  );

  always_comb begin
    state_d = state_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    step_d  = step_q;
    ndig_d  = ndig_q;
    neg_d   = neg_q;
    ov_d    = ov_q;
    char_d  = char_q;
    last_d  = last_q;

    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_beat) begin
          neg_d   = kind_i && value_i[itda_pkg::ValueWidth-1];
          // Two's complement negate; exact for the most negative value.
          bin_d   = (kind_i && value_i[itda_pkg::ValueWidth-1]) ? (~value_i + 32'd1)
                                                               : value_i;
          bcd_d   = '0;
          step_d  = '0;
          state_d = StConv;
        end
      end
      StConv: begin
        bcd_d  = bcd_step;
        bin_d  = {bin_q[itda_pkg::ValueWidth-2:0], 1'b0};
        step_d = step_q + 1'b1;
        if (step_q == StepBits'(itda_pkg::ValueWidth - 1)) begin
          ndig_d  = DigBits'(itda_pkg::DigitCount);
          state_d = StSkip;
        end
      end
      StSkip: begin
        // Drop leading zeros, keeping at least one digit.
        if (top_dig == 4'd0 && ndig_q != DigBits'(1)) begin
          bcd_d  = {bcd_q[itda_pkg::BcdWidth-5:0], 4'd0};
          ndig_d = ndig_q - 1'b1;
        end else begin
          state_d = neg_q ? StSign : StEmit;
        end
      end
      StSign: begin
        if (slot_free) begin
          ov_d    = 1'b1;
          char_d  = itda_pkg::CharMinus;
          last_d  = 1'b0;
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (slot_free) begin
          ov_d   = 1'b1;
          char_d = itda_pkg::CharZero | {4'd0, top_dig};
          last_d = (ndig_q == DigBits'(1));
          bcd_d  = {bcd_q[itda_pkg::BcdWidth-5:0], 4'd0};
          ndig_d = ndig_q - 1'b1;
          if (ndig_q == DigBits'(1)) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    step_q <= step_d;
    ndig_q <= ndig_d;
    neg_q  <= neg_d;
    char_q <= char_d;
    last_q <= last_d;
  end

endmodule

`default_nettype wire

@@ design/itda_bcd_step.sv @@
// One shift-add-3 step of the binary to BCD conversion.
`default_nettype none

module itda_bcd_step (
  input  itda_pkg::bcd_t bcd_i,
  input  logic           bit_i,
  output itda_pkg::bcd_t bcd_o
);

  itda_pkg::bcd_t adj;

  // Digits at 5 or above get +3 so the shift carries into the next digit.
  always_comb begin
    for (int i = 0; i < int'(itda_pkg::DigitCount); i++) begin
      if (bcd_i[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_i[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_i[4*i +: 4];
      end
    end
    bcd_o = {adj[itda_pkg::BcdWidth-2:0], bit_i};
  end

endmodule

`default_nettype wire

@@ design/itda_checker.sv @@
// Port-level checks for the integer to decimal ASCII converter, with bind.
`default_nettype none

module itda_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  character_o,
  input logic        is_last_o
);

  // A stalled output beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(character_o)
                                    && $stable(is_last_o))
    else $error("stalled output beat changed");

  // Busy right after taking a number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready again right after accept");

  // Only a minus sign or a decimal digit ever appears.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (character_o == itda_pkg::CharMinus) ||
                    (character_o >= itda_pkg::CharZero &&
                     character_o <= itda_pkg::CharZero + 8'd9))
    else $error("character is not a sign or digit");

  // A minus sign is never the final character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && character_o == itda_pkg::CharMinus |-> !is_last_o)
    else $error("minus sign marked last");

endmodule

bind integer_to_decimal_ascii_core itda_checker u_itda_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .character_o (character_o),
  .is_last_o   (is_last_o)
);

`default_nettype wire

@@ verif/integer_to_decimal_ascii_core_tb.sv @@
// Testbench for the integer to decimal ASCII converter: self-predicting, random stall bursts.
`timescale 1ns / 1ps

module integer_to_decimal_ascii_core_tb;

  // Kind codes on kind_i.
  localparam logic KindUnsigned = 1'b0;
  localparam logic KindSigned   = 1'b1;

  localparam int unsigned RandomCount = 408;
  // Last stretch of the run gets no new random gaps on either side.
  localparam int unsigned CalmTail    = 40;
  // Limit on cycles with no beat on either channel; far above one number's conversion plus sink stalls.
  localparam int unsigned StuckLimit  = 4000;
  // Cycles to keep watching for stray beats after the last expected one.
  localparam int unsigned TailCycles  = 80;

  typedef struct packed {
    logic        kind;
    logic [31:0] value;
    logic        drain;   // hold this number until all text is out
  } number_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_beat_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic        kind_i      = 1'b0;
  logic [31:0] value_i     = 32'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  character_o;
  logic        is_last_o;

  number_t     number_q[$];     // numbers waiting to be driven
  text_beat_t  text_q[$];       // characters still owed by the block
  int unsigned total_numbers = 0;
  int unsigned numbers_sent  = 0;
  int unsigned fail_count    = 0;
  int unsigned stuck_cycles  = 0;
  int unsigned send_gap      = 0;
  int unsigned sink_gap      = 0;
  logic        calm;

  integer_to_decimal_ascii_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .character_o(character_o),
    .is_last_o  (is_last_o)
  );

  always #6 clk_i = ~clk_i;

  assign calm = (numbers_sent + CalmTail >= total_numbers);

  // Decimal text of one number: optional '-', then digits MSD first,
  // the final one marked as last.
  function automatic void push_decimal_text(input logic kind, input logic [31:0] value);
    logic [31:0] mag;
    logic [3:0]  digs[10];
    int          n;
    begin
      mag = value;
      n   = 0;
      if (kind == KindSigned && value[31]) begin
        // two's complement magnitude; exact for 0x80000000 too
        mag = ~value + 32'd1;
        text_q.push_back('{ch: itda_pkg::CharMinus, last: 1'b0});
      end
      if (mag == 32'd0) begin
        text_q.push_back('{ch: itda_pkg::CharZero, last: 1'b1});
      end else begin
        while (mag != 32'd0) begin
          digs[n] = 4'(mag % 32'd10);
          mag     = mag / 32'd10;
          n++;
        end
        for (int k = n - 1; k >= 0; k--) begin
          text_q.push_back('{ch: itda_pkg::CharZero + 8'(digs[k]), last: (k == 0)});
        end
      end
    end
  endfunction

  // Random value biased toward digit-count edges and short texts.
  function automatic logic [31:0] pick_value();
    logic [31:0] p;
    begin
      p = 32'd1;
      case ($urandom_range(0, 5))
        0, 1: pick_value = $urandom();
        2: pick_value = $urandom() >> $urandom_range(0, 31);
        3: begin
          repeat ($urandom_range(0, 9)) p = p * 32'd10;
          pick_value = p + 32'($urandom_range(0, 2)) - 32'd1;
        end
        4: begin
          repeat ($urandom_range(0, 9)) p = p * 32'd10;
          pick_value = -(p + 32'($urandom_range(0, 2)) - 32'd1);
        end
        default: pick_value = 32'($urandom_range(0, 99));
      endcase
    end
  endfunction

  // Driver: predicts on every accepted beat, then loads the next number.
  always @(posedge clk_i or negedge rst_ni) begin
    logic    took;
    logic    next_valid;
    number_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      took       = in_valid_i && in_ready_o;
      next_valid = in_valid_i && !took;
      if (took) begin
        push_decimal_text(kind_i, value_i);
        numbers_sent++;
      end
      if (!next_valid) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (number_q.size() != 0 &&
                     !(number_q[0].drain && text_q.size() != 0)) begin
          nxt = number_q.pop_front();
          kind_i     <= nxt.kind;
          value_i    <= nxt.value;
          next_valid  = 1'b1;
          if (!calm && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 10);
        end
      end
      in_valid_i <= next_valid;
    end
  end

  // Monitor: checks each character beat against the oldest owed one.
  always @(posedge clk_i or negedge rst_ni) begin
    text_beat_t want;
    logic       next_ready;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (text_q.size() == 0) begin
          $error("unexpected beat: character %h is_last %b", character_o, is_last_o);
          fail_count++;
        end else begin
          want = text_q.pop_front();
          if (character_o !== want.ch) begin
            $error("character: expected %h, got %h", want.ch, character_o);
            fail_count++;
          end
          if (is_last_o !== want.last) begin
            $error("is_last: expected %b, got %b", want.last, is_last_o);
            fail_count++;
          end
        end
      end
      if (sink_gap != 0) begin
        sink_gap--;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) sink_gap = $urandom_range(1, 10);
      end
      out_ready_i <= next_ready;
    end
  end

  // Counts cycles with no beat on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    while (stuck_cycles < StuckLimit) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    // Directed: zero, extremes, the most negative value, digit-count edges,
    // and unsigned numbers with the top bit set.
    number_q.push_back('{kind: KindUnsigned, value: 32'd0,          drain: 1'b0});
    number_q.push_back('{kind: KindSigned,   value: 32'd0,          drain: 1'b0});
    number_q.push_back('{kind: KindUnsigned, value: 32'hFFFF_FFFF,  drain: 1'b0});
    number_q.push_back('{kind: KindSigned,   value: 32'hFFFF_FFFF,  drain: 1'b0});
    number_q.push_back('{kind: KindSigned,   value: 32'h8000_0000,  drain: 1'b1});
    number_q.push_back('{kind: KindUnsigned, value: 32'h8000_0000,  drain: 1'b0});
    number_q.push_back('{kind: KindSigned,   value: 32'h7FFF_FFFF,  drain: 1'b0});
    number_q.push_back('{kind: KindUnsigned, value: 32'h7FFF_FFFF,  drain: 1'b0});
    number_q.push_back('{kind: KindSigned,   value: 32'h8000_0001,  drain: 1'b0});
    number_q.push_back('{kind: KindUnsigned, value: 32'hFFFF_FFFE,  drain: 1'b0});
    number_q.push_back('{kind: KindUnsigned, value: 32'd1,          drain: 1'b0});
    number_q.push_back('{kind: KindSigned,   value: 32'd1,          drain: 1'b0});
    number_q.push_back('{kind: KindUnsigned, value: 32'd9,          drain: 1'b0});
    number_q.push_back('{kind: KindUnsigned, value: 32'd10,         drain: 1'b0});
    number_q.push_back('{kind: KindSigned,   value: -32'd9,         drain: 1'b0});
    number_q.push_back('{kind: KindSigned,   value: -32'd10,        drain: 1'b0});
    number_q.push_back('{kind: KindUnsigned, value: 32'd999999999,  drain: 1'b0});
    number_q.push_back('{kind: KindUnsigned, value: 32'd1000000000, drain: 1'b0});
    number_q.push_back('{kind: KindSigned,   value: -32'd1000000000, drain: 1'b0});
    number_q.push_back('{kind: KindUnsigned, value: 32'd4000000000, drain: 1'b1});
    number_q.push_back('{kind: KindSigned,   value: 32'hAAAA_AAAA,  drain: 1'b0});
    number_q.push_back('{kind: KindUnsigned, value: 32'h5555_5555,  drain: 1'b0});

    for (int i = 0; i < RandomCount; i++) begin
      number_q.push_back('{kind: 1'($urandom_range(0, 1)), value: pick_value(),
                           drain: ($urandom_range(0, 49) == 0)});
    end
    total_numbers = number_q.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (numbers_sent < total_numbers || text_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (fail_count == 0 && text_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
